@@ design/asg_pkg.sv @@
package asg_pkg;

	// register indexes on the configuration port (byte address / 4)
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_STEREO    = 2'd1;
	localparam logic [1:0] REG_LIMIT     = 2'd2;

	localparam logic [15:0] THRESHOLD_RST = 16'd50;
	localparam logic        STEREO_RST    = 1'b0;
	localparam logic [23:0] LIMIT_RST     = 24'd3400;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one 64-bit PCM word, sample a in the low lane
	typedef struct packed {
		logic [15:0] d;
		logic [15:0] c;
		logic [15:0] b;
		logic [15:0] a;
	} word_t;

	// one result word as it waits in the output queue
	typedef struct packed {
		word_t word;
		logic  fin;
	} entry_t;

	// results produced by one accepted input word
	typedef struct packed {
		logic [1:0] cnt;
		entry_t     e0;
		entry_t     e1;
	} push_t;

	// magnitude of a difference wrapped to 16 bits, 0..32768
	function automatic logic [16:0] wrap_mag(input logic [15:0] x, input logic [15:0] y);
		logic [15:0] d;
		d = x - y;
		if (d[15]) begin
			return 17'h10000 - {1'b0, d};
		end
		return {1'b0, d};
	endfunction

endpackage

@@ design/asg_pair_test.sv @@
module asg_pair_test (
	input  asg_pkg::word_t held,
	input  asg_pkg::word_t cur,
	input  logic [15:0]    threshold,
	input  logic           stereo,
	output logic           quiet
);
	import asg_pkg::*;

	logic [7:0][15:0] s;
	logic [7:1]       loud;

	assign s = {cur.d, cur.c, cur.b, cur.a, held.d, held.c, held.b, held.a};

	// each sample against the first of its channel, all in parallel
	always_comb begin
		for (int i = 1; i < 8; i++) begin
			if (stereo && i[0]) begin
				loud[i] = (i == 1) ? 1'b0 : (wrap_mag(s[i], s[1]) > {1'b0, threshold});
			end else begin
				loud[i] = wrap_mag(s[i], s[0]) > {1'b0, threshold};
			end
		end
	end

	assign quiet = ~|loud;

endmodule

@@ design/asg_out_queue.sv @@
module asg_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  asg_pkg::push_t   push,
	input  logic             pop,
	output asg_pkg::entry_t  head,
	output logic             head_valid,
	output logic             has_room
);
	import asg_pkg::*;

	entry_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic [QPTR_W-1:0]   wr_ptr_p1;

	assign wr_ptr_p1  = wr_ptr_q + 1'b1;
	assign head       = fifo_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	// room for the two words one input can produce
	assign has_room   = (count_q <= (QPTR_W+1)'(QUEUE_DEPTH - 2));

	// storage, written in order e0 then e1
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			fifo_q[wr_ptr_q] <= push.e0;
		end
		if (push.cnt == 2'd2) begin
			fifo_q[wr_ptr_p1] <= push.e1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(push.cnt) - (QPTR_W+1)'(pop);
		end
	end

endmodule

@@ design/audio_silence_gate.sv @@
// audio_silence_gate: drops long quiet stretches from a PCM word stream.
// Input channel (in_valid/in_ready) carries one 64-bit word of four signed
// 16-bit samples plus end_of_stream. The output channel (out_valid/out_ready)
// carries kept words; final_word marks the last kept word of a stream.
// Each accepted word is tested together with the previously held word, and
// zero, one or two words (held word, and the current one on end of stream)
// go into a four-word output queue in the same cycle.
// A kept word is written into the queue when the word that decides it is
// accepted (the queue write is the only register in the path).
// Throughput: one input word per cycle; in_ready only depends on the queue
// fill (high while at most two words are queued), so a stalled receiver backs
// up into in_ready once three or more words wait, and nothing is lost.
// Reset clears the held word, run counter, silence flag and the queue, and
// loads threshold 50, mono mode, and a limit of 3400 quiet words.
// Registers (APB, 32-bit): 0x0 amplitude threshold, 0x4 stereo mode,
// 0x8 silence word limit; write them only while the block is idle.
module audio_silence_gate (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input words
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample_a,
	input  logic signed [15:0] sample_b,
	input  logic signed [15:0] sample_c,
	input  logic signed [15:0] sample_d,
	input  logic               end_of_stream,
	// kept words
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_sample_a,
	output logic signed [15:0] out_sample_b,
	output logic signed [15:0] out_sample_c,
	output logic signed [15:0] out_sample_d,
	output logic               final_word
);
	import asg_pkg::*;

	logic [15:0] threshold_q;
	logic        stereo_q;
	logic [23:0] limit_q;

	word_t       held_word_q;
	logic        held_valid_q;
	logic [23:0] quiet_run_q;
	logic        in_silence_q;

	word_t       cur;
	logic        quiet;
	logic        in_fire;
	logic        cfg_wr;
	logic [23:0] run_inc;
	logic [23:0] run_d;
	logic        sil_d;
	logic        emit_held;
	logic        emit_cur;
	push_t       push;
	entry_t      head;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			stereo_q    <= STEREO_RST;
			limit_q     <= LIMIT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_THRESHOLD: threshold_q <= pwdata[15:0];
				REG_STEREO:    stereo_q    <= pwdata[0];
				REG_LIMIT:     limit_q     <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_THRESHOLD: prdata = {16'd0, threshold_q};
			REG_STEREO:    prdata = {31'd0, stereo_q};
			REG_LIMIT:     prdata = {8'd0, limit_q};
			default:       prdata = 32'd0;
		endcase
	end

	// pair test of held and current word
	assign cur = '{d: sample_d, c: sample_c, b: sample_b, a: sample_a};

	asg_pair_test u_pair (
		.held      (held_word_q),
		.cur       (cur),
		.threshold (threshold_q),
		.stereo    (stereo_q),
		.quiet     (quiet)
	);

	assign in_fire = in_valid & in_ready;
	assign run_inc = quiet_run_q + 24'd1;

	// run counter and gate decision
	always_comb begin
		run_d     = quiet_run_q;
		sil_d     = in_silence_q;
		emit_held = 1'b0;
		if (held_valid_q) begin
			emit_held = !quiet || !in_silence_q;
			if (quiet) begin
				if (!in_silence_q) begin
					run_d = run_inc;
					sil_d = (run_inc >= limit_q);
				end
			end else begin
				run_d = '0;
				sil_d = 1'b0;
			end
		end
		emit_cur = end_of_stream && !sil_d;
	end

	// words handed to the output queue
	always_comb begin
		push.e1.word = cur;
		push.e1.fin  = 1'b1;
		if (emit_held) begin
			push.e0.word = held_word_q;
			push.e0.fin  = end_of_stream && !emit_cur;
		end else begin
			push.e0.word = cur;
			push.e0.fin  = 1'b1;
		end
		push.cnt = in_fire ? ({1'b0, emit_held} + {1'b0, emit_cur}) : 2'd0;
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			quiet_run_q  <= '0;
			in_silence_q <= 1'b0;
		end else if (in_fire) begin
			held_valid_q <= !end_of_stream;
			quiet_run_q  <= end_of_stream ? 24'd0 : run_d;
			in_silence_q <= end_of_stream ? 1'b0 : sil_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_word_q <= '0;
		end else if (in_fire) begin
			held_word_q <= cur;
		end
	end

	asg_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (out_valid & out_ready),
		.head       (head),
		.head_valid (out_valid),
		.has_room   (in_ready)
	);

	assign out_sample_a = head.word.a;
	assign out_sample_b = head.word.b;
	assign out_sample_c = head.word.c;
	assign out_sample_d = head.word.d;
	assign final_word   = head.fin;

	// checks
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && end_of_stream) |=> (!held_valid_q && !in_silence_q && quiet_run_q == '0))
		else $error("end of stream did not clear the stream state");

	a_silence_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_silence_q |-> held_valid_q)
		else $error("gate in silence with no held word");

	a_no_push_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> in_ready)
		else $error("queue written without room");

endmodule
